// ----- rtl/core/sfsdm_pkg.sv -----
// shared types and codes for the scanout frame slot damage manager
package sfsdm_pkg;

    localparam int COORD_W  = 16;
    localparam int SERIAL_W = 32;

    // operation codes
    localparam logic [2:0] OP_SET_GEOM    = 3'd0;
    localparam logic [2:0] OP_UPDATE      = 3'd1;
    localparam logic [2:0] OP_ACK         = 3'd2;
    localparam logic [2:0] OP_DISABLE     = 3'd3;
    localparam logic [2:0] OP_XPORT_RESET = 3'd4;

    // result status codes
    localparam logic [2:0] ST_SENT     = 3'd0;
    localparam logic [2:0] ST_NOCHANGE = 3'd1;
    localparam logic [2:0] ST_ACK_OK   = 3'd2;
    localparam logic [2:0] ST_ACK_BAD  = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_NOSCAN   = 3'd5;
    localparam logic [2:0] ST_WAIT     = 3'd6;
    localparam logic [2:0] ST_DISABLE  = 3'd7;

    // frame kinds
    localparam logic [1:0] KIND_REG_FRAME = 2'd0;
    localparam logic [1:0] KIND_FRAME     = 2'd1;
    localparam logic [1:0] KIND_DISABLE   = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic               valid;
    } rect_t;

    typedef struct packed {
        logic                alloc;
        logic                regd;
        logic                busy;
        logic                valid;
        logic [SERIAL_W-1:0] serial;
        rect_t               dmg;
    } slot_t;

endpackage

// ----- rtl/core/scanout_frame_slot_damage_manager.sv -----
// scanout frame slot manager: one row per scanout in a synchronous memory
// a result is registered from the final state after calc, clip, merge and merge2; it stalls while a result waits
// transport reset sweeps every scanout row, a read and a write state per row, before its result
// no new item is taken until the read/modify/write pass over the scanout row memory is done
// after aresetn, a clearing pass writes every row; no item is taken until it ends
// aresetn is synchronous and active low; the output valid is cleared by it
module scanout_frame_slot_damage_manager
    import sfsdm_pkg::*;
#(
    parameter int NUM_SCANOUTS = 16,
    parameter int NUM_SLOTS    = 3,
    parameter int COORD_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [3:0]  s_scanout,
    input  logic [31:0] s_resource,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [15:0] s_size_w,
    input  logic [15:0] s_size_h,
    input  logic [2:0]  s_ack_slot,
    input  logic [31:0] s_ack_serial,
    input  logic        s_ack_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_slot_num,
    output logic [31:0] m_frame_serial,
    output logic [1:0]  m_frame_kind,
    output logic [31:0] m_src_surface,
    output logic [15:0] m_dst_x,
    output logic [15:0] m_dst_y,
    output logic [15:0] m_copy_w,
    output logic [15:0] m_copy_h,
    output logic [16:0] m_src_x,
    output logic [16:0] m_src_y,
    output logic        m_full_copy
);

    localparam int AW = (NUM_SCANOUTS > 1) ? $clog2(NUM_SCANOUTS) : 1;
    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [15:0] CMASK =
        (COORD_BITS >= 16) ? 16'hFFFF : 16'((1 << COORD_BITS) - 1);
    localparam logic [AW-1:0] LAST_ROW = AW'(NUM_SCANOUTS - 1);

    typedef struct packed {
        logic [15:0]           width;
        logic [15:0]           height;
        logic [15:0]           org_x;
        logic [15:0]           org_y;
        logic [SW-1:0]         ptr;
        logic [31:0]           serial_ctr;
        slot_t [NUM_SLOTS-1:0] slots;
    } row_t;

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_CALC   = 9'b000000100,
        S_CLIP   = 9'b000001000,
        S_MERGE  = 9'b000010000,
        S_MERGE2 = 9'b000100000,
        S_FIN    = 9'b001000000,
        S_SWP_RD = 9'b010000000,
        S_SWP_WR = 9'b100000000
    } state_t;

    function automatic row_t cleared_row();
        row_t r;
        r = '0;
        r.serial_ctr = 32'd1;
        return r;
    endfunction

    state_t state_reg, state_next;

    row_t mem [NUM_SCANOUTS];
    row_t rdata_reg;
    row_t row_reg;

    logic [AW-1:0] swp_idx_reg;

    // latched item
    logic [2:0]  op_reg;
    logic [3:0]  scan_reg;
    logic [31:0] res_reg;
    logic [15:0] px_reg, py_reg, pw_reg, ph_reg;
    logic [2:0]  aslot_reg;
    logic [31:0] aser_reg;
    logic        aok_reg;

    // work registers
    logic [2:0]  stat_reg;
    logic        issue_reg, wr_reg, clip_reg;
    rect_t       inc_reg;
    logic [31:0] dis_serial_reg;
    logic [15:0] ix0_reg, iy0_reg;
    logic [16:0] ix1_reg, iy1_reg;
    logic [SW-1:0] sel_reg;
    logic [15:0] x0_reg [NUM_SLOTS];
    logic [15:0] y0_reg [NUM_SLOTS];
    logic [16:0] x1_reg [NUM_SLOTS];
    logic [16:0] y1_reg [NUM_SLOTS];
    rect_t       mrg_reg [NUM_SLOTS];

    // output register
    logic        m_valid_reg;
    logic [2:0]  o_status_reg;
    logic [1:0]  o_slot_reg;
    logic [31:0] o_serial_reg;
    logic [1:0]  o_kind_reg;
    logic [31:0] o_res_reg;
    logic [15:0] o_dx_reg, o_dy_reg, o_w_reg, o_h_reg;
    logic [16:0] o_sx_reg, o_sy_reg;
    logic        o_full_reg;

    logic accept, fin_fire;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign fin_fire = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // calc stage: decode against the row just read
    row_t        row_c;
    logic [2:0]  stat_c;
    logic        issue_c, wr_c, clip_c, busy_c, size_chg, bad_scan;
    rect_t       inc_c;
    logic [16:0] sx1_c, sy1_c, dx1_c, dy1_c;

    always_comb begin
        row_c    = rdata_reg;
        stat_c   = ST_NOCHANGE;
        issue_c  = 1'b0;
        wr_c     = 1'b0;
        clip_c   = 1'b0;
        inc_c.x  = '0;
        inc_c.y  = '0;
        inc_c.w  = rdata_reg.width;
        inc_c.h  = rdata_reg.height;
        inc_c.valid = 1'b1;
        busy_c   = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            busy_c = busy_c | rdata_reg.slots[k].busy;
        end
        size_chg = (rdata_reg.width != pw_reg) || (rdata_reg.height != ph_reg);
        bad_scan = ({28'd0, scan_reg} >= 32'(NUM_SCANOUTS));
        if (op_reg > OP_XPORT_RESET || (op_reg <= OP_DISABLE && bad_scan)) begin
            stat_c = ST_INVALID;
        end else begin
            unique case (op_reg)
                OP_SET_GEOM: begin
                    if (pw_reg == '0 || ph_reg == '0) begin
                        stat_c = ST_INVALID;
                    end else if (size_chg && busy_c) begin
                        stat_c = ST_WAIT;
                    end else begin
                        if (size_chg) begin
                            row_c        = cleared_row();
                            row_c.width  = pw_reg;
                            row_c.height = ph_reg;
                        end
                        row_c.org_x = px_reg;
                        row_c.org_y = py_reg;
                        inc_c.w     = pw_reg;
                        inc_c.h     = ph_reg;
                        issue_c     = 1'b1;
                    end
                end
                OP_UPDATE: begin
                    if (rdata_reg.width == '0 || rdata_reg.height == '0) begin
                        stat_c = ST_NOSCAN;
                    end else begin
                        issue_c = 1'b1;
                        clip_c  = (pw_reg != '0) && (ph_reg != '0);
                    end
                end
                OP_ACK: begin
                    stat_c = aok_reg ? ST_ACK_OK : ST_ACK_BAD;
                    wr_c   = 1'b1;
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        if (3'(k) == aslot_reg && rdata_reg.slots[k].busy &&
                            rdata_reg.slots[k].serial == aser_reg) begin
                            row_c.slots[k].busy   = 1'b0;
                            row_c.slots[k].serial = '0;
                        end
                    end
                end
                OP_DISABLE: begin
                    if (busy_c) begin
                        stat_c = ST_WAIT;
                    end else begin
                        stat_c = ST_DISABLE;
                        row_c  = cleared_row();
                        wr_c   = 1'b1;
                    end
                end
                default: begin
                    stat_c = ST_NOCHANGE;
                end
            endcase
        end
        // clip bounds against the scanout window
        sx1_c = {1'b0, rdata_reg.org_x} + {1'b0, rdata_reg.width};
        sy1_c = {1'b0, rdata_reg.org_y} + {1'b0, rdata_reg.height};
        dx1_c = {1'b0, px_reg} + {1'b0, pw_reg};
        dy1_c = {1'b0, py_reg} + {1'b0, ph_reg};
    end

    // clip stage: finish the clip and pick the next free slot
    rect_t         inc_n;
    logic          empty_c, found_c;
    logic [SW-1:0] sel_c;
    logic [SW:0]   cand_c;
    logic [2:0]    stat_n;
    logic          issue_n;

    always_comb begin
        inc_n   = inc_reg;
        empty_c = clip_reg && (({1'b0, ix0_reg} >= ix1_reg) || ({1'b0, iy0_reg} >= iy1_reg));
        if (clip_reg) begin
            inc_n.x = ix0_reg - row_reg.org_x;
            inc_n.y = iy0_reg - row_reg.org_y;
            inc_n.w = 16'(ix1_reg - {1'b0, ix0_reg});
            inc_n.h = 16'(iy1_reg - {1'b0, iy0_reg});
        end
        found_c = 1'b0;
        sel_c   = '0;
        cand_c  = '0;
        for (int n = 0; n < NUM_SLOTS; n++) begin
            cand_c = (SW+1)'(row_reg.ptr) + (SW+1)'(n);
            if (cand_c >= (SW+1)'(NUM_SLOTS)) begin
                cand_c = cand_c - (SW+1)'(NUM_SLOTS);
            end
            if (!found_c && !row_reg.slots[cand_c[SW-1:0]].busy) begin
                found_c = 1'b1;
                sel_c   = cand_c[SW-1:0];
            end
        end
        stat_n  = stat_reg;
        issue_n = issue_reg;
        if (issue_reg) begin
            if (empty_c) begin
                stat_n  = ST_NOCHANGE;
                issue_n = 1'b0;
            end else if (!found_c) begin
                stat_n  = ST_WAIT;
                issue_n = 1'b0;
            end else begin
                stat_n = ST_SENT;
            end
        end
    end

    // merge lanes: one per slot
    logic [15:0] x0_c [NUM_SLOTS];
    logic [15:0] y0_c [NUM_SLOTS];
    logic [16:0] x1_c [NUM_SLOTS];
    logic [16:0] y1_c [NUM_SLOTS];
    rect_t       mrg_c [NUM_SLOTS];
    logic [16:0] ax1, bx1, ay1, by1;

    always_comb begin
        ax1 = '0;
        bx1 = '0;
        ay1 = '0;
        by1 = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            ax1 = {1'b0, row_reg.slots[k].dmg.x} + {1'b0, row_reg.slots[k].dmg.w};
            bx1 = {1'b0, inc_reg.x} + {1'b0, inc_reg.w};
            ay1 = {1'b0, row_reg.slots[k].dmg.y} + {1'b0, row_reg.slots[k].dmg.h};
            by1 = {1'b0, inc_reg.y} + {1'b0, inc_reg.h};
            x0_c[k] = (row_reg.slots[k].dmg.x < inc_reg.x) ? row_reg.slots[k].dmg.x
                                                            : inc_reg.x;
            y0_c[k] = (row_reg.slots[k].dmg.y < inc_reg.y) ? row_reg.slots[k].dmg.y
                                                            : inc_reg.y;
            x1_c[k] = (ax1 > bx1) ? ax1 : bx1;
            y1_c[k] = (ay1 > by1) ? ay1 : by1;
            if (row_reg.slots[k].dmg.valid) begin
                mrg_c[k].x     = x0_reg[k];
                mrg_c[k].y     = y0_reg[k];
                mrg_c[k].w     = 16'(x1_reg[k] - {1'b0, x0_reg[k]}) & CMASK;
                mrg_c[k].h     = 16'(y1_reg[k] - {1'b0, y0_reg[k]}) & CMASK;
                mrg_c[k].valid = 1'b1;
            end else begin
                mrg_c[k] = inc_reg;
            end
        end
    end

    // final stage: new row and copy command
    row_t        row_n;
    rect_t       cd;
    logic        vld_sel;
    logic [1:0]  kind_c;
    logic [16:0] srcx_c, srcy_c;
    logic        full_c;

    always_comb begin
        row_n   = row_reg;
        vld_sel = row_reg.slots[sel_reg].alloc && row_reg.slots[sel_reg].valid;
        cd.x    = '0;
        cd.y    = '0;
        cd.w    = row_reg.width;
        cd.h    = row_reg.height;
        cd.valid = 1'b1;
        if (vld_sel) begin
            cd = mrg_reg[sel_reg];
        end
        kind_c = row_reg.slots[sel_reg].regd ? KIND_FRAME : KIND_REG_FRAME;
        srcx_c = {1'b0, row_reg.org_x} + {1'b0, cd.x};
        srcy_c = {1'b0, row_reg.org_y} + {1'b0, cd.y};
        full_c = (cd.x == '0) && (cd.y == '0) && (cd.w == row_reg.width) &&
                 (cd.h == row_reg.height);
        if (issue_reg) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (row_reg.slots[k].alloc && row_reg.slots[k].valid) begin
                    row_n.slots[k].dmg = mrg_reg[k];
                end
            end
            row_n.ptr = ((SW+1)'(sel_reg) + 1'b1 == (SW+1)'(NUM_SLOTS)) ? '0
                                                                        : sel_reg + 1'b1;
            row_n.slots[sel_reg].alloc  = 1'b1;
            row_n.slots[sel_reg].valid  = 1'b1;
            row_n.slots[sel_reg].regd   = 1'b1;
            row_n.slots[sel_reg].busy   = 1'b1;
            row_n.slots[sel_reg].serial = row_reg.serial_ctr;
            row_n.slots[sel_reg].dmg    = '0;
            row_n.serial_ctr            = row_reg.serial_ctr + 32'd1;
        end
    end

    // transport reset drops registration and busy marks of a row
    row_t swept_c;

    always_comb begin
        swept_c = rdata_reg;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            swept_c.slots[k].regd   = 1'b0;
            swept_c.slots[k].busy   = 1'b0;
            swept_c.slots[k].serial = '0;
        end
    end

    // state sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:   if (swp_idx_reg == LAST_ROW) state_next = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_op == OP_XPORT_RESET) ? S_SWP_RD : S_CALC;
                end
            end
            S_CALC:   state_next = S_CLIP;
            S_CLIP:   state_next = S_MERGE;
            S_MERGE:  state_next = S_MERGE2;
            S_MERGE2: state_next = S_FIN;
            S_FIN:    if (fin_fire) state_next = S_IDLE;
            S_SWP_RD: state_next = S_SWP_WR;
            S_SWP_WR: state_next = (swp_idx_reg == LAST_ROW) ? S_FIN : S_SWP_RD;
            default:  state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            swp_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INIT || state_reg == S_SWP_WR) begin
                swp_idx_reg <= (swp_idx_reg == LAST_ROW) ? '0 : swp_idx_reg + 1'b1;
            end
        end
    end

    // row memory: one read port, one write port
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= mem[AW'(s_scanout)];
        end else if (state_reg == S_SWP_RD) begin
            rdata_reg <= mem[swp_idx_reg];
        end
        if (state_reg == S_INIT) begin
            mem[swp_idx_reg] <= cleared_row();
        end else if (state_reg == S_SWP_WR) begin
            mem[swp_idx_reg] <= swept_c;
        end else if (fin_fire && (issue_reg || wr_reg)) begin
            mem[AW'(scan_reg)] <= row_n;
        end
    end

    // item and work registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_op;
            scan_reg  <= s_scanout;
            res_reg   <= s_resource;
            px_reg    <= s_pos_x & CMASK;
            py_reg    <= s_pos_y & CMASK;
            pw_reg    <= s_size_w & CMASK;
            ph_reg    <= s_size_h & CMASK;
            aslot_reg <= s_ack_slot;
            aser_reg  <= s_ack_serial;
            aok_reg   <= s_ack_ok;
            stat_reg  <= ST_NOCHANGE;
            issue_reg <= 1'b0;
            wr_reg    <= 1'b0;
        end
        if (state_reg == S_CALC) begin
            row_reg        <= row_c;
            stat_reg       <= stat_c;
            issue_reg      <= issue_c;
            wr_reg         <= wr_c;
            clip_reg       <= clip_c;
            inc_reg        <= inc_c;
            dis_serial_reg <= rdata_reg.serial_ctr;
            ix0_reg <= (rdata_reg.org_x > px_reg) ? rdata_reg.org_x : px_reg;
            iy0_reg <= (rdata_reg.org_y > py_reg) ? rdata_reg.org_y : py_reg;
            ix1_reg <= (sx1_c < dx1_c) ? sx1_c : dx1_c;
            iy1_reg <= (sy1_c < dy1_c) ? sy1_c : dy1_c;
        end
        if (state_reg == S_CLIP) begin
            inc_reg   <= inc_n;
            stat_reg  <= stat_n;
            issue_reg <= issue_n;
            sel_reg   <= sel_c;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (state_reg == S_MERGE) begin
                x0_reg[k] <= x0_c[k];
                y0_reg[k] <= y0_c[k];
                x1_reg[k] <= x1_c[k];
                y1_reg[k] <= y1_c[k];
            end
            if (state_reg == S_MERGE2) begin
                mrg_reg[k] <= mrg_c[k];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            o_status_reg <= stat_reg;
            o_slot_reg   <= '0;
            o_serial_reg <= '0;
            o_kind_reg   <= '0;
            o_res_reg    <= '0;
            o_dx_reg     <= '0;
            o_dy_reg     <= '0;
            o_w_reg      <= '0;
            o_h_reg      <= '0;
            o_sx_reg     <= '0;
            o_sy_reg     <= '0;
            o_full_reg   <= 1'b0;
            if (issue_reg) begin
                o_slot_reg   <= 2'(sel_reg);
                o_serial_reg <= row_reg.serial_ctr;
                o_kind_reg   <= kind_c;
                o_res_reg    <= res_reg;
                o_dx_reg     <= cd.x;
                o_dy_reg     <= cd.y;
                o_w_reg      <= cd.w;
                o_h_reg      <= cd.h;
                o_sx_reg     <= srcx_c;
                o_sy_reg     <= srcy_c;
                o_full_reg   <= full_c;
            end else if (stat_reg == ST_DISABLE) begin
                o_serial_reg <= dis_serial_reg;
                o_kind_reg   <= KIND_DISABLE;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = o_status_reg;
    assign m_slot_num      = o_slot_reg;
    assign m_frame_serial  = o_serial_reg;
    assign m_frame_kind    = o_kind_reg;
    assign m_src_surface   = o_res_reg;
    assign m_dst_x         = o_dx_reg;
    assign m_dst_y         = o_dy_reg;
    assign m_copy_w        = o_w_reg;
    assign m_copy_h        = o_h_reg;
    assign m_src_x         = o_sx_reg;
    assign m_src_y         = o_sy_reg;
    assign m_full_copy     = o_full_reg;

    // a frame is only issued into a slot that is not busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && issue_reg) |-> !row_reg.slots[sel_reg].busy)
        else $error("frame issued into busy slot");

    // row writes never target a scanout beyond the configured count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && (issue_reg || wr_reg)) |-> ({28'd0, scan_reg} < 32'(NUM_SCANOUTS)))
        else $error("row write outside scanout range");

    // results other than a sent frame carry no copy command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_SENT) |-> (m_copy_w == '0 && m_copy_h == '0 &&
                                              m_src_surface == '0 && !m_full_copy))
        else $error("copy fields set without a sent frame");

    // every result follows an item transfer: a new result only after the final stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final stage");

endmodule
